FILE: rtl/core/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg: shared types for the timed action queue sequencer
// Opcode and drive-mode codes, stream word layouts and the fixed part of a
// queued command.
// ----------------------------------------------------------------------------
package tas_pkg;

  // opcodes carried on in_tuser
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_PAUSE  = 3'd1,
    OP_ARM    = 3'd2,
    OP_TURN   = 3'd3,
    OP_STRAFE = 3'd4,
    OP_PNEU   = 3'd5
  } opcode_t;

  // drive output modes
  typedef enum logic [1:0] {
    DRV_NONE   = 2'd0,
    DRV_STRAFE = 2'd1,
    DRV_ROTATE = 2'd2,
    DRV_STOP   = 2'd3
  } drive_mode_t;

  localparam logic [7:0] SPEED_ZERO   = 8'd127;
  localparam logic [7:0] SPEED_REJECT = 8'h80;
  localparam int         IN_DUR_W     = 20;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic [3:0]          pad;
    logic [3:0]          arm_sensed;
    logic [15:0]         valve_flags;
    logic [3:0]          arm_target;
    logic signed [7:0]   speed_y;
    logic signed [7:0]   speed_x;
    logic [IN_DUR_W-1:0] duration;
  } in_data_t;

  // result word fields that do not depend on the queue depth
  typedef struct packed {
    logic        command_done;
    logic [15:0] valve_out;
    logic [3:0]  arm_request_state;
    logic [7:0]  drive_b;
    logic [7:0]  drive_a;
    logic        accepted;
  } out_res_t;

  // result user sideband
  typedef struct packed {
    logic        valve_valid;
    logic        arm_request_valid;
    drive_mode_t drive_mode;
  } out_user_t;

  // queued command without its duration
  typedef struct packed {
    logic [15:0] flags;
    logic [3:0]  target;
    logic [7:0]  speed_b;
    logic [7:0]  speed_a;
    opcode_t     kind;
  } cmd_fix_t;

endpackage

FILE: rtl/core/tas_ram.sv
// ----------------------------------------------------------------------------
// tas_ram: generic single-port-write ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tas_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tas_out_buf.sv
// ----------------------------------------------------------------------------
// tas_out_buf: result register with skid stage
// Holds the finished result word and takes one more while the receiver stalls.
// ----------------------------------------------------------------------------
module tas_out_buf #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [DATA_W-1:0] s_data,
  output logic              m_valid,
  input  logic              m_ready,
  output logic [DATA_W-1:0] m_data
);

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  logic [DATA_W-1:0] main_d_r, main_d_nxt;
  logic [DATA_W-1:0] skid_d_r, skid_d_nxt;
  logic              fire;

  assign s_ready = !skid_v_r;
  assign fire    = s_valid && !skid_v_r;

  // refill the main register from skid first, else from the input
  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!main_v_r || m_ready) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = fire;
        main_d_nxt = s_data;
      end
    end else if (fire) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = s_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign m_valid = main_v_r;
  assign m_data  = main_d_r;

endmodule

FILE: rtl/core/timed_action_queue_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_action_queue_sequencer_unit: ring queue of timed actuator commands
// Enqueues pause, arm, turn, strafe and valve commands and runs the head
// command on each tick word.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel: one word per item, opcode on in_tuser. Opcodes 1..5 append a
//   command at the tail (rejected when full or on a speed of -128); opcode 0
//   is a tick that runs the head command and may retire it.
//   out_* channel: exactly one result word per input word, in order.
//   The result is registered in the output register, or in the skid stage
//   while the receiver stalls. Throughput: one word per cycle while
//   in_tready is high; the head command is kept prefetched from the command
//   ram (read address is the next head) for back-to-back ticks and enqueues.
//   Reset (rst_n low, synchronous): queue empty, progress counter cleared, no
//   result pending. No clearing pass; the command ram is not initialized.
//   Stall: a result waits in the output register while one more word is taken
//   into a skid stage; in_tready drops only when both are full.
// ----------------------------------------------------------------------------
module timed_action_queue_sequencer_unit
  import tas_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int DURATION_BITS = 20,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int RES_W      = $bits(out_res_t),
  localparam int OUT_DATA_W = ((RES_W + CNT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // duration[19:0], speed_x[27:20], speed_y[35:28], arm_target[39:36],
  // valve_flags[55:40], arm_sensed[59:56], zero pad
  input  logic [63:0]           in_tdata,
  // opcode[2:0]
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // accepted[0], drive_a[8:1], drive_b[16:9], arm_request_state[20:17],
  // valve_out[36:21], command_done[37], queue_count above, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // drive_mode[1:0], arm_request_valid[2], valve_valid[3]
  output logic [3:0]            out_tuser
);

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int FIX_W   = $bits(cmd_fix_t);
  localparam int ENTRY_W = DURATION_BITS + FIX_W;
  localparam int PROG_W  = DURATION_BITS + 1;
  localparam int SUM_W   = CNT_W + 1;
  localparam int BUF_W   = CNT_W + $bits(out_user_t) + RES_W;

  in_data_t             in_d;
  opcode_t              op;
  logic                 in_acc;

  logic [ADDR_W-1:0]    head_r, head_nxt, head_inc, tail;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PROG_W-1:0]    prog_r, prog_nxt;
  logic                 byp_r, byp_nxt;
  logic [ENTRY_W-1:0]   wr_ent_r;

  logic [ENTRY_W-1:0]   ram_q, head_ent, ent;
  cmd_fix_t             head_fix, ent_fix;
  logic [DURATION_BITS-1:0] head_dur, ent_dur;
  logic [SUM_W-1:0]     tail_sum;
  logic                 full, enq_ok, we, tdone, done;

  out_res_t             res;
  out_user_t            usr;
  logic [BUF_W-1:0]     buf_in, buf_out;

  assign in_d   = in_data_t'(in_tdata);
  assign op     = opcode_t'(in_tuser);
  assign in_acc = in_tvalid && in_tready;

  // head entry: bypass the word just written into an empty queue
  assign head_ent = byp_r ? wr_ent_r : ram_q;
  assign head_fix = cmd_fix_t'(head_ent[FIX_W-1:0]);
  assign head_dur = head_ent[ENTRY_W-1:FIX_W];

  // ring pointers
  assign head_inc = (head_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = SUM_W'(head_r) + SUM_W'(cnt_r);
  assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    ADDR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : ADDR_W'(tail_sum);
  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));

  // new command from the input word
  always_comb begin
    ent_fix         = '0;
    ent_fix.kind    = op;
    ent_fix.speed_a = SPEED_ZERO;
    ent_fix.speed_b = SPEED_ZERO;
    ent_dur         = DURATION_BITS'(in_d.duration);
    enq_ok          = 1'b1;
    case (op)
      OP_ARM: begin
        ent_fix.target = in_d.arm_target;
      end
      OP_TURN: begin
        enq_ok          = ($unsigned(in_d.speed_x) != SPEED_REJECT);
        ent_fix.speed_a = 8'(SPEED_ZERO + $unsigned(in_d.speed_x));
      end
      OP_STRAFE: begin
        enq_ok          = ($unsigned(in_d.speed_x) != SPEED_REJECT) &&
                          ($unsigned(in_d.speed_y) != SPEED_REJECT);
        ent_fix.speed_a = 8'(SPEED_ZERO - $unsigned(in_d.speed_x));
        ent_fix.speed_b = 8'(SPEED_ZERO + $unsigned(in_d.speed_y));
      end
      OP_PNEU: begin
        ent_dur       = '0;
        ent_fix.flags = in_d.valve_flags;
      end
      default: ;
    endcase
  end

  assign ent   = {ent_dur, ent_fix};
  assign tdone = ({1'b0, head_dur} < prog_r);

  // per-item processing: tick on the head command or enqueue at the tail
  always_comb begin
    res          = '0;
    res.drive_a  = SPEED_ZERO;
    res.drive_b  = SPEED_ZERO;
    usr          = '0;
    usr.drive_mode = DRV_NONE;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    prog_nxt     = prog_r;
    we           = 1'b0;
    done         = 1'b0;
    if (in_acc) begin
      case (op)
        OP_TICK: begin
          if (cnt_r != '0) begin
            res.accepted = 1'b1;
            case (head_fix.kind)
              OP_STRAFE, OP_TURN: begin
                done = tdone;
                if (tdone) begin
                  usr.drive_mode = DRV_STOP;
                end else begin
                  usr.drive_mode = (head_fix.kind == OP_STRAFE) ? DRV_STRAFE : DRV_ROTATE;
                  res.drive_a    = head_fix.speed_a;
                  res.drive_b    = head_fix.speed_b;
                end
              end
              OP_ARM: begin
                usr.arm_request_valid = 1'b1;
                res.arm_request_state = head_fix.target;
                done = (in_d.arm_sensed == head_fix.target) || tdone;
              end
              OP_PNEU: begin
                usr.valve_valid = 1'b1;
                res.valve_out   = head_fix.flags;
                done            = 1'b1;
              end
              default: begin
                done = tdone;
              end
            endcase
            if (done) begin
              head_nxt = head_inc;
              cnt_nxt  = cnt_r - 1'b1;
              prog_nxt = '0;
            end else begin
              prog_nxt = prog_r + 1'b1;
            end
          end
        end
        OP_PAUSE, OP_ARM, OP_TURN, OP_STRAFE, OP_PNEU: begin
          if (!full && enq_ok) begin
            we           = 1'b1;
            cnt_nxt      = cnt_r + 1'b1;
            res.accepted = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.command_done = done;
  end

  assign byp_nxt = we && (cnt_r == '0);

  // queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      prog_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      prog_r <= prog_nxt;
      byp_r  <= byp_nxt;
    end
  end

  // copy of the last written command for the bypass
  always_ff @(posedge clk) begin
    if (we) begin
      wr_ent_r <= ent;
    end
  end

  // command store, read address follows the next head
  tas_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tail),
    .wdata (ent),
    .raddr (head_nxt),
    .rdata (ram_q)
  );

  // result register and skid stage
  assign buf_in = {cnt_nxt, usr, res};

  tas_out_buf #(
    .DATA_W (BUF_W)
  ) u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (buf_in),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (buf_out)
  );

  assign out_tdata = OUT_DATA_W'({buf_out[BUF_W-1 -: CNT_W], buf_out[RES_W-1:0]});
  assign out_tuser = buf_out[RES_W +: 4];

`ifndef SYNTHESIS
  // fill count stays within the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // progress never runs past the longest duration plus one
  assert property (@(posedge clk) disable iff (!rst_n)
    prog_r <= (PROG_W'(1) << DURATION_BITS))
    else $error("progress counter overrun");

  // a retiring command restarts the progress count
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done) |=> (prog_r == '0))
    else $error("progress not cleared on retire");

  // bypass only follows a write into an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> (cnt_r == CNT_W'(1)))
    else $error("head bypass with wrong fill count");
`endif

endmodule
